// ----- sv/idns_pkg.sv -----
package idns_pkg;

   // Search name storage
   localparam int MAX_NAME = 128;
   localparam int NAME_AW  = $clog2(MAX_NAME);
   localparam int NAME_LW  = $clog2(MAX_NAME + 1);

   // Directory record layout (byte offsets inside one record)
   localparam logic [7:0] OFS_LENGTH   = 8'd0;
   localparam logic [7:0] OFS_LBA_LO   = 8'd2;
   localparam logic [7:0] OFS_LBA_HI   = 8'd5;
   localparam logic [7:0] OFS_ID_LEN   = 8'd32;
   localparam logic [7:0] OFS_ID_START = 8'd33;

   typedef enum logic {
      OP_NAME = 1'b0,
      OP_DIR  = 1'b1
   } op_type;

endpackage

// ----- sv/idns_name_store.sv -----
module idns_name_store (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [idns_pkg::NAME_AW-1:0]  wr_addr,
   input  logic [7:0]                    wr_data,
   input  logic [idns_pkg::NAME_AW-1:0]  rd_addr,
   output logic [7:0]                    rd_data
);
   import idns_pkg::*;

   logic [7:0] store_mem [MAX_NAME];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   // read is issued every cycle with the address of the next record offset
   always_ff @(posedge clock) begin
      rd_data_ff <= store_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/iso_directory_name_search.sv -----
// A result beat is registered from the directory beat that decides it and is presented in the cycle after it.
// Throughput: one beat per cycle on the request side, name bytes and directory bytes alike;
//   the request side stalls only while a result beat is held with rsp_tready low.
// The name store is read one offset ahead, so each directory byte finds its name byte ready.
// Reset (synchronous, active high) clears the walk state and the output valid; the name is
//   empty and complete after reset. Name store contents are not cleared.
module iso_directory_name_search (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] value
   input  logic        req_tuser,   // [0] operation: 0 name byte, 1 directory byte
   input  logic        req_tlast,   // final name byte or final directory byte
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] lba
   output logic        rsp_tuser    // [0] found
);
   import idns_pkg::*;

   // walk state
   logic [NAME_LW-1:0] name_length_ff, name_length_in;
   logic               name_complete_ff, name_complete_in;
   logic [7:0]         record_offset_ff, record_offset_in;
   logic [7:0]         record_length_ff, record_length_in;
   logic [7:0]         id_length_ff, id_length_in;
   logic [31:0]        extent_ff, extent_in;
   logic               matching_ff, matching_in;
   logic               finished_ff, finished_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [31:0]        rsp_lba_ff, rsp_lba_in;

   // name store ports
   logic               wr_en;
   logic [NAME_AW-1:0] wr_addr;
   logic [NAME_AW-1:0] rd_addr;
   logic [7:0]         ref_byte;

   logic               beat;
   op_type             op;
   logic [7:0]         v;
   logic               emit;
   logic               emit_found;
   logic [31:0]        emit_lba;
   logic [NAME_LW-1:0] base_len;
   logic [8:0]         off_inc;
   logic [7:0]         idx;
   logic [7:0]         lane_ofs;
   logic [1:0]         lane;
   logic [7:0]         rd_ofs;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign beat       = req_tvalid && req_tready;
   assign op         = op_type'(req_tuser);
   assign v          = req_tdata;

   assign idx        = record_offset_ff - OFS_ID_START;
   assign lane_ofs   = record_offset_ff - OFS_LBA_LO;
   assign lane       = lane_ofs[1:0];
   assign off_inc    = {1'b0, record_offset_ff} + 9'd1;

   // a new name begins at address zero when the previous one was closed
   assign base_len   = name_complete_ff ? '0 : name_length_ff;
   assign wr_en      = beat && (op == OP_NAME) && (32'(base_len) < MAX_NAME);
   assign wr_addr    = base_len[NAME_AW-1:0];

   // prefetch the name byte for the offset the walk moves to
   assign rd_ofs     = record_offset_in - OFS_ID_START;
   assign rd_addr    = rd_ofs[NAME_AW-1:0];

   idns_name_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (v),
      .rd_addr (rd_addr),
      .rd_data (ref_byte)
   );

   always_comb begin
      name_length_in   = name_length_ff;
      name_complete_in = name_complete_ff;
      record_offset_in = record_offset_ff;
      record_length_in = record_length_ff;
      id_length_in     = id_length_ff;
      extent_in        = extent_ff;
      matching_in      = matching_ff;
      finished_in      = finished_ff;
      emit             = 1'b0;
      emit_found       = 1'b0;
      emit_lba         = '0;

      if (beat && op == OP_NAME) begin
         name_length_in   = wr_en ? base_len + NAME_LW'(1) : base_len;
         name_complete_in = req_tlast;
         record_offset_in = '0;
         record_length_in = '0;
         id_length_in     = '0;
         extent_in        = '0;
         matching_in      = 1'b0;
         finished_in      = 1'b0;
      end else if (beat && op == OP_DIR) begin
         if (!finished_ff) begin
            if (record_offset_ff == OFS_LENGTH) begin
               record_length_in = v;
               if (v == 8'd0) begin
                  // zero-length record ends the directory
                  emit = 1'b1;
               end
            end else if (record_offset_ff >= OFS_LBA_LO && record_offset_ff <= OFS_LBA_HI) begin
               extent_in[lane*8 +: 8] = v;
            end else if (record_offset_ff == OFS_ID_LEN) begin
               id_length_in = v;
               // record must be long enough to carry the whole identifier
               matching_in  = (9'(v) == 9'(name_length_ff)) &&
                              ({1'b0, record_length_ff} >= 9'(OFS_ID_START) + 9'(v));
               if (matching_in && v == 8'd0) begin
                  emit       = 1'b1;
                  emit_found = 1'b1;
                  emit_lba   = extent_ff;
               end
            end else if (record_offset_ff > OFS_ID_LEN && idx < id_length_ff && matching_ff) begin
               matching_in = (v == ref_byte);
               if (matching_in && (9'(idx) + 9'd1 == 9'(id_length_ff))) begin
                  emit       = 1'b1;
                  emit_found = 1'b1;
                  emit_lba   = extent_ff;
               end
            end

            if (emit) begin
               finished_in = 1'b1;
            end else begin
               record_offset_in = (off_inc >= {1'b0, record_length_in}) ? 8'd0 : off_inc[7:0];
            end

            if (req_tlast && !emit) begin
               // block ended without a hit
               emit       = 1'b1;
               emit_found = 1'b0;
               emit_lba   = '0;
            end
         end

         if (req_tlast) begin
            record_offset_in = '0;
            record_length_in = '0;
            id_length_in     = '0;
            extent_in        = '0;
            matching_in      = 1'b0;
            finished_in      = 1'b0;
         end
      end
   end

   // result register loads whenever it is free or being drained
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_lba_in   = rsp_lba_ff;
      if (req_tready) begin
         rsp_valid_in = emit;
         if (emit) begin
            rsp_found_in = emit_found;
            rsp_lba_in   = emit_lba;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         name_length_ff   <= '0;
         name_complete_ff <= 1'b1;
         record_offset_ff <= '0;
         record_length_ff <= '0;
         id_length_ff     <= '0;
         extent_ff        <= '0;
         matching_ff      <= 1'b0;
         finished_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         name_length_ff   <= name_length_in;
         name_complete_ff <= name_complete_in;
         record_offset_ff <= record_offset_in;
         record_length_ff <= record_length_in;
         id_length_ff     <= id_length_in;
         extent_ff        <= extent_in;
         matching_ff      <= matching_in;
         finished_ff      <= finished_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff <= rsp_found_in;
      rsp_lba_ff   <= rsp_lba_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_lba_ff;
   assign rsp_tuser  = rsp_found_ff;

   // a new result only follows a directory beat
   a_rsp_from_dir: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(beat && op == OP_DIR))
      else $error("result without a directory beat");

   // not found always carries a zero lba
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> rsp_lba_ff == 32'd0)
      else $error("miss with nonzero lba");

   // a name beat abandons the walk
   a_name_restarts: assert property (@(posedge clock) disable iff (reset)
      beat && op == OP_NAME |=> !finished_ff && record_offset_ff == 8'd0)
      else $error("walk not restarted by name beat");

   // stored name never exceeds the store
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      32'(name_length_ff) <= MAX_NAME)
      else $error("name length overflow");

endmodule

// ----- test/iso_directory_name_search_test.sv -----
`timescale 1ns / 1ps

module iso_directory_name_search_test;
   import idns_pkg::*;

   // Ending of a directed directory block
   typedef enum logic [1:0] {
      TAIL_END,   // last flag on the final record byte
      TAIL_ZERO,  // a zero-length record byte closes the block
      TAIL_CUT,   // block ends in the middle of the record
      TAIL_OPEN   // block stops without last, the next name load drops it
   } tail_kind_type;

   typedef struct packed {
      logic        found;
      logic [31:0] lba;
   } search_result_type;

   // One directed case: optional name load, then one record.
   // name_len 0 keeps the current name. Expected result typed in where known.
   typedef struct packed {
      int            name_len;
      logic [7:0]    name_seed;
      int            rec_len;
      logic [31:0]   lba;
      int            id_len;
      logic [7:0]    id_seed;
      tail_kind_type tail;
      bit            known;
      bit            exp_found;
      logic [31:0]   exp_lba;
   } dir_case_type;

   localparam int ITEMS       = 950;
   localparam int CUT_AT      = 21;   // bytes sent before a cut or abandoned block

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] value
   logic        req_tuser;    // [0] operation
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;    // [31:0] lba
   logic        rsp_tuser;    // [0] found

   iso_directory_name_search u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // ------------------------------------------------------------------
   // Directed cases
   // ------------------------------------------------------------------
   dir_case_type directed_cases [12] = '{
      // empty name right after reset matches a record with no name
      '{0,   8'h00, 34,  32'hFFFF_FFFF, 0,   8'h00, TAIL_END,  1, 1, 32'hFFFF_FFFF},
      // a name byte of value zero is a real character
      '{1,   8'h00, 34,  32'h0000_0000, 1,   8'h00, TAIL_END,  1, 1, 32'h0000_0000},
      // hit, then the trailing zero record is ignored
      '{1,   8'hFF, 34,  32'h1234_5678, 1,   8'hFF, TAIL_ZERO, 1, 1, 32'h1234_5678},
      // one name byte off, zero record ends the walk
      '{0,   8'h00, 34,  32'h0BAD_F00D, 1,   8'hFE, TAIL_ZERO, 1, 0, 32'h0},
      // record too short to hold its name
      '{3,   8'h41, 35,  32'h0000_0035, 3,   8'h41, TAIL_ZERO, 1, 0, 32'h0},
      // name length differs
      '{0,   8'h00, 35,  32'h0000_0001, 2,   8'h41, TAIL_END,  1, 0, 32'h0},
      // over-long name keeps its first MAX_NAME bytes
      '{130, 8'h10, 161, 32'hA5A5_5A5A, 128, 8'h10, TAIL_END,  1, 1, 32'hA5A5_5A5A},
      // full-size record with id length 255, spills into the next record
      '{0,   8'h00, 255, 32'h7777_7777, 255, 8'h10, TAIL_END,  0, 0, 32'h0},
      // record cut off by the block end
      '{2,   8'h61, 40,  32'h0000_1111, 2,   8'h61, TAIL_CUT,  1, 0, 32'h0},
      // walk abandoned by the next name load, no result
      '{0,   8'h00, 40,  32'h2222_2222, 2,   8'h61, TAIL_OPEN, 0, 0, 32'h0},
      // fresh block after the abandoned walk
      '{2,   8'h61, 40,  32'h3333_3333, 2,   8'h61, TAIL_END,  1, 1, 32'h3333_3333},
      // zero-length first record, rest of the block ignored
      '{0,   8'h00, 0,   32'h4444_4444, 3,   8'h00, TAIL_END,  1, 0, 32'h0}
   };

   // ------------------------------------------------------------------
   // Shared run state
   // ------------------------------------------------------------------
   search_result_type awaited [$];     // results still to come, oldest first
   logic [7:0]        dir_bytes [$];   // directory block being assembled
   bit                typed_block;     // expectation of this block typed in
   bit                quiet;           // no idling on either side for now
   int                hold_cycles;     // receiver long hold-off request
   int                beats_in;
   int                results_seen;
   int                hits_seen;
   int                mismatches;

   // ------------------------------------------------------------------
   // Predictor: own copy of the search state
   // ------------------------------------------------------------------
   logic [7:0]  name_mem [MAX_NAME];
   int unsigned name_len;
   bit          name_done;
   int unsigned rec_pos;
   int unsigned rec_len;
   int unsigned id_len;
   logic [31:0] extent;
   bit          matching;
   bit          finished;

   function automatic void restart_walk();
      rec_pos  = 0;
      rec_len  = 0;
      id_len   = 0;
      extent   = '0;
      matching = 1'b0;
      finished = 1'b0;
   endfunction

   // Advance the search by one accepted beat, queue the result it causes
   function automatic void follow_beat(op_type op, logic [7:0] v, logic lst);
      int unsigned       pos;
      int unsigned       vv;
      int unsigned       idx;
      bit                emit;
      search_result_type r;
      emit = 1'b0;
      r    = '0;
      vv   = v;
      beats_in++;
      if (op == OP_NAME) begin
         if (name_done) begin
            name_len  = 0;
            name_done = 1'b0;
         end
         if (name_len < MAX_NAME) begin
            name_mem[name_len] = v;
            name_len++;
         end
         if (lst) name_done = 1'b1;
         restart_walk();
         return;
      end
      if (finished) begin
         if (lst) restart_walk();
         return;
      end
      pos = rec_pos;
      if (pos == OFS_LENGTH) begin
         rec_len = vv;
         if (vv == 0) emit = 1'b1;
      end else if (pos >= OFS_LBA_LO && pos <= OFS_LBA_HI) begin
         extent[8 * (pos - OFS_LBA_LO) +: 8] = v;
      end else if (pos == OFS_ID_LEN) begin
         id_len   = vv;
         matching = (vv == name_len) && (rec_len >= 33 + vv);
         if (matching && vv == 0) begin
            emit    = 1'b1;
            r.found = 1'b1;
            r.lba   = extent;
         end
      end else if (pos > OFS_ID_LEN && pos - OFS_ID_START < id_len && matching) begin
         idx = pos - OFS_ID_START;
         if (v != ((idx < MAX_NAME) ? name_mem[idx] : 8'h00)) matching = 1'b0;
         if (matching && idx + 1 == id_len) begin
            emit    = 1'b1;
            r.found = 1'b1;
            r.lba   = extent;
         end
      end
      if (emit) begin
         finished = 1'b1;
      end else begin
         pos++;
         rec_pos = (pos >= rec_len) ? 0 : pos;
      end
      if (lst) begin
         emit = 1'b1;   // end of block answers not found unless already answered
         restart_walk();
      end
      if (emit && !typed_block) awaited.push_back(r);
   endfunction

   // Idle length: mostly none or short, now and then long
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // ------------------------------------------------------------------
   // Clock and reset
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard limit on run time
   initial begin
      #20_000_000;
      $display("FAIL iso_directory_name_search");
      $finish;
   end

   // ------------------------------------------------------------------
   // Request side: drive at the falling edge, accept at the rising edge.
   // Called at a falling edge, returns at a falling edge with tvalid still
   // high, so back-to-back beats never drop tvalid in between.
   // ------------------------------------------------------------------
   task automatic send_beat(op_type op, logic [7:0] v, logic lst);
      int unsigned gap;
      gap = quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= v;
      req_tlast  <= lst;
      do begin
         @(posedge clock);
      end while (req_tready !== 1'b1);
      follow_beat(op, v, lst);
      @(negedge clock);
   endtask

   // Drop tvalid before any wait that is not a beat
   task automatic idle_request();
      req_tvalid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      idle_request();
      while (awaited.size() != 0) @(negedge clock);
   endtask

   // Send the first n assembled directory bytes, then drop the block
   task automatic send_dir(int unsigned n, bit lst);
      int unsigned k;
      for (k = 0; k < n; k++) send_beat(OP_DIR, dir_bytes[k], lst && (k == n - 1));
      dir_bytes.delete();
   endtask

   // Append one record; bytes past the record length spill into the next one
   function automatic void add_record(int unsigned rlen, logic [31:0] lba,
                                      logic [7:0] id [$]);
      int unsigned k;
      int unsigned total;
      int unsigned base;
      base  = dir_bytes.size();
      total = (rlen > 33 + id.size()) ? rlen : 33 + id.size();
      for (k = 0; k < total; k++) dir_bytes.push_back(8'($urandom));
      dir_bytes[base + OFS_LENGTH] = 8'(rlen);
      for (k = 0; k < 4; k++) dir_bytes[base + OFS_LBA_LO + k] = lba[8 * k +: 8];
      dir_bytes[base + OFS_ID_LEN] = 8'(id.size());
      foreach (id[k]) dir_bytes[base + OFS_ID_START + k] = id[k];
   endfunction

   // Name load: mostly short names, rarely past MAX_NAME, sometimes left open
   task automatic random_name();
      int unsigned len;
      int unsigned pick;
      int unsigned k;
      pick = $urandom_range(0, 99);
      if (pick < 90) len = $urandom_range(1, 8);
      else if (pick < 98) len = $urandom_range(9, 40);
      else len = $urandom_range(MAX_NAME - 4, MAX_NAME + 12);
      for (k = 0; k < len; k++)
         send_beat(OP_NAME, 8'($urandom), (k == len - 1) && ($urandom_range(0, 9) != 0));
   endtask

   // Records whose names are the current name, near misses of it, or random names
   task automatic random_records(int unsigned nrec);
      int unsigned k;
      int unsigned j;
      int unsigned rlen;
      int unsigned pick;
      logic [7:0]  id [$];
      for (k = 0; k < nrec; k++) begin
         id = {};
         for (j = 0; j < name_len; j++) id.push_back(name_mem[j]);
         pick = $urandom_range(0, 7);
         if ((pick == 3 || pick == 7) && id.size() > 0) begin
            j = $urandom_range(0, id.size() - 1);
            id[j] = id[j] ^ (8'h01 << $urandom_range(0, 7));
         end else if (pick == 4 && id.size() > 0) begin
            void'(id.pop_back());
         end else if (pick == 5) begin
            id.push_back(8'($urandom));
         end else if (pick == 6) begin
            id = {};
            repeat ($urandom_range(0, 10)) id.push_back(8'($urandom));
         end
         rlen = 33 + id.size() + $urandom_range(0, 3);
         if ($urandom_range(0, 9) == 0) rlen = $urandom_range(1, 32 + id.size());
         if (rlen > 255) rlen = 255;
         add_record(rlen, $urandom, id);
      end
   endtask

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin
      dir_case_type c;
      logic [7:0]   id [$];
      int unsigned  k;
      int unsigned  pick;
      int unsigned  cut;
      int           drain_wait;
      bit           pressure_done;

      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      req_tlast   = 1'b0;
      typed_block = 1'b0;
      quiet       = 1'b0;
      hold_cycles = 0;
      beats_in    = 0;
      pressure_done = 1'b0;
      foreach (name_mem[k]) name_mem[k] = 8'h00;
      name_len  = 0;
      name_done = 1'b1;
      restart_walk();

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part
      foreach (directed_cases[i]) begin
         c     = directed_cases[i];
         quiet = ($urandom_range(0, 2) == 0);
         for (k = 0; k < c.name_len; k++)
            send_beat(OP_NAME, 8'(c.name_seed + k), k == c.name_len - 1);
         id = {};
         for (k = 0; k < c.id_len; k++) id.push_back(8'(c.id_seed + k));
         add_record(c.rec_len, c.lba, id);
         if (c.tail == TAIL_ZERO) dir_bytes.push_back(8'h00);
         if (c.known) begin
            awaited.push_back('{found: c.exp_found, lba: c.exp_lba});
            typed_block = 1'b1;
         end
         case (c.tail)
            TAIL_CUT:  send_dir(CUT_AT, 1'b1);
            TAIL_OPEN: send_dir(CUT_AT, 1'b0);
            default:   send_dir(dir_bytes.size(), 1'b1);
         endcase
         typed_block = 1'b0;
      end

      // Random part: mostly well-formed blocks against the current name
      while (beats_in < ITEMS) begin
         quiet = ($urandom_range(0, 3) == 0);

         if (!pressure_done && beats_in >= 400) begin
            // Sender waits for all results, then the receiver holds off while
            // one-byte blocks answer at once, so the result register fills and the request side stalls
            wait_drained();
            quiet       = 1'b1;
            hold_cycles = 300;
            repeat (40) send_beat(OP_DIR, 8'h00, 1'b1);
            wait_drained();
            pressure_done = 1'b1;
            quiet = 1'b0;
         end

         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            random_name();
         end else if (pick < 75) begin
            random_records($urandom_range(1, 3));
            case ($urandom_range(0, 3))
               0:       dir_bytes.push_back(8'h00);
               1:       repeat ($urandom_range(1, 4)) dir_bytes.push_back(8'($urandom));
               default: ;
            endcase
            send_dir(dir_bytes.size(), 1'b1);
         end else if (pick < 88) begin
            // noise block: random bytes of random length
            k = $urandom_range(1, 12);
            repeat (k) dir_bytes.push_back(8'($urandom));
            send_dir(k, 1'b1);
         end else begin
            // broken block: cut short, or abandoned by a name load
            random_records($urandom_range(1, 2));
            cut = $urandom_range(1, dir_bytes.size());
            if ($urandom_range(0, 1)) begin
               send_dir(cut, 1'b1);
            end else begin
               send_dir(cut, 1'b0);
               random_name();
            end
         end
      end

      // Drain, bounded, then a short settle for stray results
      quiet = 1'b0;
      idle_request();
      drain_wait = 0;
      while (awaited.size() != 0 && drain_wait < 5000) begin
         @(negedge clock);
         drain_wait++;
      end
      repeat (8) @(negedge clock);
      if (awaited.size() != 0) begin
         $error("%0d expected results never arrived", awaited.size());
         mismatches += awaited.size();
      end

      $display("Covered %0d request beats: directed records, random names and blocks,",
               beats_in);
      $display("short, cut and abandoned records; %0d results (%0d hits), full-block stall.",
               results_seen, hits_seen);
      if (mismatches == 0) begin
         $display("PASS iso_directory_name_search");
      end else begin
         $display("FAIL iso_directory_name_search");
      end
      $finish;
   end

   // ------------------------------------------------------------------
   // Result side: tready changes at the falling edge. A long hold-off is
   // counted here; otherwise random stalls unless in a quiet stretch.
   // ------------------------------------------------------------------
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
            rsp_tready <= (stall_left == 0);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Compare each accepted result beat with the oldest expectation
   always @(posedge clock) begin
      search_result_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (awaited.size() == 0) begin
            $error("unexpected result: found %0d lba %h", rsp_tuser, rsp_tdata);
            mismatches++;
         end else begin
            want = awaited.pop_front();
            if (rsp_tuser !== want.found) begin
               $error("found: expected %0d, actual %0d", want.found, rsp_tuser);
               mismatches++;
            end
            if (rsp_tdata !== want.lba) begin
               $error("lba: expected %h, actual %h", want.lba, rsp_tdata);
               mismatches++;
            end
         end
         results_seen++;
         if (rsp_tuser === 1'b1) hits_seen++;
      end
   end

   initial begin
      results_seen = 0;
      hits_seen    = 0;
      mismatches   = 0;
   end

endmodule

// ----- iso_directory_name_search.f -----
sv/idns_pkg.sv
sv/idns_name_store.sv
sv/iso_directory_name_search.sv
test/iso_directory_name_search_test.sv
